FILE: rtl/rsw_pkg.sv
`timescale 1ns / 1ps

package rsw_pkg;

	// default table geometry
	localparam int MAX_ENTRIES_DEF  = 64;
	localparam int FITNESS_BITS_DEF = 16;

	// fixed field widths on the stream ports
	localparam int REQ_W       = 2;
	localparam int FIT_IN_W    = 16;
	localparam int RAND_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int INDEX_OUT_W = 6;
	localparam int FIT_OUT_W   = 16;
	localparam int LIVE_OUT_W  = 7;

	// packed stream words, padded to whole bytes
	localparam int IN_DATA_W  = ((FIT_IN_W + RAND_W + 7) / 8) * 8;
	localparam int OUT_RAW_W  = INDEX_OUT_W + FIT_OUT_W + LIVE_OUT_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int IN_USER_W  = REQ_W;
	localparam int OUT_USER_W = STATUS_W;

	// remainder step counter of the serial modulo
	localparam int DIV_CNT_W = $clog2(RAND_W);

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_PICK  = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_THRESH,
		S_WALK,
		S_REMOVE,
		S_RESP
	} state_t;

endpackage

FILE: rtl/rsw_ram.sv
`timescale 1ns / 1ps

module rsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/roulette_selection_without_replacement_top.sv
`timescale 1ns / 1ps
// clear, load and unused requests: result is set in S_DECODE, then registered for output in S_RESP
// pick: 32-step serial modulo, one threshold multiply, then one stored entry read per cycle
//   through a 3-stage compare pipe; ends early on a hit
// one request at a time: a new transfer is taken once the previous result sits in the output
// register; reset clears the counts and the output valid, the fitness memory and live bits stay
module roulette_selection_without_replacement_top
	import rsw_pkg::*;
#(
	parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
	parameter int FITNESS_BITS = FITNESS_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // fitness_value[15:0], random_word[47:16]
	input  logic [IN_USER_W-1:0]  s_tuser,   // req_type[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // chosen_index[5:0], chosen_fitness[21:6],
	                                         // live_count[28:22], zero above
	output logic [OUT_USER_W-1:0] m_tuser    // status[1:0]
);

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int TOT_W  = FITNESS_BITS + CNT_W;
	localparam int PROD_W = TOT_W + CNT_W;
	localparam int MEM_W  = FITNESS_BITS + 1;

	state_t state_q, state_d;

	// control state
	logic [CNT_W-1:0]     loaded_q;
	logic [CNT_W-1:0]     live_q;
	logic [TOT_W-1:0]     total_q;
	logic [CNT_W-1:0]     issue_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 vld_s1, vld_s2, vld_s3;
	logic                 found_q, any_q;
	logic                 m_tvalid_q;

	// request and work registers
	req_t                    req_q;
	logic [FITNESS_BITS-1:0] fit_q;
	logic [RAND_W-1:0]       rand_q;
	logic [CNT_W-1:0]        rem_q;
	logic [PROD_W-1:0]       thresh_q;
	logic [TOT_W-1:0]        run_q;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3;
	logic [FITNESS_BITS-1:0] fit_s2, fit_s3;
	logic [TOT_W-1:0]        run_s2;
	logic [PROD_W-1:0]       prod_s3;
	logic [IDX_W-1:0]        pick_idx_q;
	logic [FITNESS_BITS-1:0] pick_fit_q;

	// result waiting for the output register
	status_t                 res_status_q;
	logic [IDX_W-1:0]        res_idx_q;
	logic [FITNESS_BITS-1:0] res_fit_q;
	logic [CNT_W-1:0]        res_live_q;

	// output register
	status_t                out_status_q;
	logic [INDEX_OUT_W-1:0] out_idx_q;
	logic [FIT_OUT_W-1:0]   out_fit_q;
	logic [LIVE_OUT_W-1:0]  out_live_q;

	// memory port and shared units
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [MEM_W-1:0]     ram_wdata;
	logic [IDX_W-1:0]     ram_raddr;
	logic [MEM_W-1:0]     ram_rdata;
	logic [TOT_W-1:0]     mul_a;
	logic [CNT_W-1:0]     mul_b;
	logic [PROD_W-1:0]    mul_p;
	logic [CNT_W:0]       div_shift;
	logic                 div_ge;
	logic [CNT_W:0]       div_diff;
	logic                 issuing;
	logic                 out_load;
	logic                 in_xfer;
	logic                 table_full;
	logic                 walk_done;
	logic                 rd_live;
	logic [FITNESS_BITS-1:0] rd_fit;
	logic [TOT_W-1:0]     run_sum;

	// fitness memory, top bit marks a live entry
	rsw_ram #(
		.WIDTH(MEM_W),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_xfer    = s_tvalid && s_tready;
	assign table_full = (loaded_q >= CNT_W'(MAX_ENTRIES));
	assign rd_live    = ram_rdata[FITNESS_BITS];
	assign rd_fit     = ram_rdata[FITNESS_BITS-1:0];
	assign run_sum    = run_q + TOT_W'(rd_fit);
	assign walk_done  = found_q || ((issue_q == loaded_q) && !vld_s1 && !vld_s2 && !vld_s3);

	// shared multiplier
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// one restoring step of random_word mod live count
	assign div_shift = {rem_q, rand_q[RAND_W-1]};
	assign div_ge    = (div_shift >= {1'b0, live_q});
	assign div_diff  = div_shift - {1'b0, live_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (req_q == REQ_PICK && live_q != '0) begin
					state_d = S_DIV;
				end else begin
					state_d = S_RESP;
				end
			end
			S_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = S_THRESH;
				end
			end
			S_THRESH: state_d = S_WALK;
			S_WALK: begin
				if (walk_done) begin
					state_d = S_REMOVE;
				end
			end
			S_REMOVE: state_d = S_RESP;
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = loaded_q[IDX_W-1:0];
		ram_wdata = {1'b1, fit_q};
		ram_raddr = issue_q[IDX_W-1:0];
		mul_a     = run_s2;
		mul_b     = live_q;
		issuing   = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_DECODE: begin
				if (req_q == REQ_LOAD && !table_full) begin
					ram_we = 1'b1;
				end
			end
			S_DIV: ;
			S_THRESH: begin
				mul_a = total_q;
				mul_b = rem_q + CNT_W'(1);
			end
			S_WALK: issuing = (issue_q < loaded_q) && !found_q;
			S_REMOVE: begin
				if (any_q) begin
					ram_we    = 1'b1;
					ram_waddr = pick_idx_q;
					ram_wdata = {1'b0, pick_fit_q};
				end
			end
			S_RESP: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			loaded_q   <= '0;
			live_q     <= '0;
			total_q    <= '0;
			issue_q    <= '0;
			div_cnt_q  <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			found_q    <= 1'b0;
			any_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// table bookkeeping
			if (state_q == S_DECODE) begin
				if (req_q == REQ_CLEAR) begin
					loaded_q <= '0;
					live_q   <= '0;
					total_q  <= '0;
				end else if (req_q == REQ_LOAD && !table_full) begin
					loaded_q <= loaded_q + CNT_W'(1);
					live_q   <= live_q + CNT_W'(1);
					total_q  <= total_q + TOT_W'(fit_q);
				end
				div_cnt_q <= DIV_CNT_W'(RAND_W - 1);
			end else if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end else if (state_q == S_REMOVE && any_q) begin
				live_q  <= live_q - CNT_W'(1);
				total_q <= total_q - TOT_W'(pick_fit_q);
			end

			// walk control
			if (state_q == S_THRESH) begin
				issue_q <= '0;
				found_q <= 1'b0;
				any_q   <= 1'b0;
			end else if (issuing) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			vld_s1 <= issuing;
			vld_s2 <= vld_s1 && rd_live && (state_q == S_WALK);
			vld_s3 <= vld_s2 && (state_q == S_WALK);
			if (state_q == S_WALK && vld_s3 && !found_q) begin
				any_q <= 1'b1;
				if (total_q != '0 && prod_s3 >= thresh_q) begin
					found_q <= 1'b1;
				end
			end

			// output handshake
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q  <= req_t'(s_tuser[REQ_W-1:0]);
			fit_q  <= FITNESS_BITS'(s_tdata[FIT_IN_W-1:0]);
			rand_q <= s_tdata[FIT_IN_W +: RAND_W];
		end

		// request decode and immediate results
		if (state_q == S_DECODE) begin
			rem_q     <= '0;
			res_fit_q <= '0;
			unique case (req_q)
				REQ_CLEAR: begin
					res_status_q <= STAT_OK;
					res_idx_q    <= '0;
					res_live_q   <= '0;
				end
				REQ_LOAD: begin
					if (table_full) begin
						res_status_q <= STAT_FULL;
						res_idx_q    <= '0;
						res_live_q   <= live_q;
					end else begin
						res_status_q <= STAT_OK;
						res_idx_q    <= loaded_q[IDX_W-1:0];
						res_live_q   <= live_q + CNT_W'(1);
					end
				end
				REQ_PICK: begin
					res_status_q <= STAT_EMPTY;
					res_idx_q    <= '0;
					res_live_q   <= '0;
				end
				REQ_NOP: begin
					res_status_q <= STAT_OK;
					res_idx_q    <= '0;
					res_live_q   <= live_q;
				end
				default: ;
			endcase
		end

		// serial modulo
		if (state_q == S_DIV) begin
			rem_q  <= div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
			rand_q <= rand_q << 1;
		end

		// threshold (k + 1) * total
		if (state_q == S_THRESH) begin
			thresh_q <= mul_p;
			run_q    <= '0;
		end

		// walk pipe: read, accumulate, multiply, compare
		idx_s1 <= issue_q[IDX_W-1:0];
		if (vld_s1 && rd_live) begin
			run_q <= run_sum;
		end
		run_s2  <= run_sum;
		idx_s2  <= idx_s1;
		fit_s2  <= rd_fit;
		prod_s3 <= mul_p;
		idx_s3  <= idx_s2;
		fit_s3  <= fit_s2;
		if (state_q == S_WALK && vld_s3 && !found_q) begin
			pick_idx_q <= idx_s3;
			pick_fit_q <= fit_s3;
		end

		// removal result
		if (state_q == S_REMOVE) begin
			if (any_q) begin
				res_status_q <= STAT_OK;
				res_idx_q    <= pick_idx_q;
				res_fit_q    <= pick_fit_q;
				res_live_q   <= live_q - CNT_W'(1);
			end else begin
				res_status_q <= STAT_EMPTY;
				res_idx_q    <= '0;
				res_fit_q    <= '0;
				res_live_q   <= '0;
			end
		end

		// output register load
		if (out_load) begin
			out_status_q <= res_status_q;
			out_idx_q    <= INDEX_OUT_W'(res_idx_q);
			out_fit_q    <= FIT_OUT_W'(res_fit_q);
			out_live_q   <= LIVE_OUT_W'(res_live_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(OUT_DATA_W - OUT_RAW_W){1'b0}}, out_live_q, out_fit_q, out_idx_q};

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rsw_pkg::*;

	localparam int  TABLE_DEPTH = MAX_ENTRIES_DEF;
	localparam int  CYCLE_LIMIT = 1_000_000;
	localparam int  END_SETTLE  = 20;

	// one expected result of a request
	typedef struct {
		status_t      status;
		logic [5:0]   index;
		logic [15:0]  fitness;
		logic [6:0]   live;
	} selection_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // fitness_value, random_word
	logic [IN_USER_W-1:0]  s_tuser = '0;   // req_type
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // chosen_index, chosen_fitness, live_count
	logic [OUT_USER_W-1:0] m_tuser;        // status

	roulette_selection_without_replacement_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// shadow copy of the selection table
	logic [15:0]            fitness_table [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] live_slots = '0;
	int unsigned            loaded_slots = 0;
	int unsigned            live_entries = 0;
	longint unsigned        fitness_sum = 0;

	selection_t  expected_selections [$];
	selection_t  head;
	int unsigned error_count = 0;
	int unsigned sent_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// work out the result of one accepted request and queue it
	function automatic void predict_selection(req_t req, logic [15:0] fit, logic [31:0] word);
		selection_t      res;
		longint unsigned n, k, thresh, run;
		int              pick;
		res.status  = STAT_OK;
		res.index   = '0;
		res.fitness = '0;
		run  = 0;
		pick = 0;
		case (req)
			REQ_CLEAR: begin
				live_slots   = '0;
				loaded_slots = 0;
				live_entries = 0;
				fitness_sum  = 0;
			end
			REQ_LOAD: begin
				if (loaded_slots >= TABLE_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					fitness_table[loaded_slots] = fit;
					live_slots[loaded_slots]    = 1'b1;
					res.index    = 6'(loaded_slots);
					loaded_slots = loaded_slots + 1;
					live_entries = live_entries + 1;
					fitness_sum  = fitness_sum + fit;
				end
			end
			REQ_PICK: begin
				if (live_entries == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					n      = live_entries;
					k      = word % n;
					thresh = (k + 1) * fitness_sum;
					// first live entry whose running share reaches (k+1)/n,
					// else the last live one
					for (int i = 0; i < loaded_slots; i++) begin
						if (live_slots[i]) begin
							pick = i;
							if (fitness_sum != 0) begin
								run = run + fitness_table[i];
								if (run * n >= thresh)
									break;
							end
						end
					end
					live_slots[pick] = 1'b0;
					live_entries     = live_entries - 1;
					fitness_sum      = fitness_sum - fitness_table[pick];
					res.index        = 6'(pick);
					res.fitness      = fitness_table[pick];
				end
			end
			default: ;
		endcase
		res.live = 7'(live_entries);
		expected_selections.insert(expected_selections.size(), res);
	endfunction

	function automatic void check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_selections.size() == 0) begin
				$error("result transfer with no request pending");
				error_count++;
			end else begin
				head = expected_selections.pop_front();
				check_field("status", head.status, m_tuser);
				check_field("chosen_index", head.index, m_tdata[5:0]);
				check_field("chosen_fitness", head.fitness, m_tdata[21:6]);
				check_field("live_count", head.live, m_tdata[28:22]);
			end
		end
	end

	// send one request; valid stays up after the transfer for the next call
	task automatic send_request(req_t req, logic [15:0] fit, logic [31:0] word);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({word, fit});
		s_tuser  <= req;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_selection(req, fit, word);
		sent_count++;
	endtask

	// hold the sender until every outstanding result is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_selections.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] rand_fitness();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 4))
			0:       return $urandom_range(0, 127);
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// empty table picks and the unused request code
	task automatic test_empty_and_unused();
		send_request(REQ_PICK, 16'h0000, 32'h0000_0000);
		send_request(REQ_PICK, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(REQ_NOP, 16'h0000, 32'h0000_0000);
		send_request(REQ_NOP, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(REQ_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	// field extremes on loads and picks, draining the table to empty
	task automatic test_field_extremes();
		send_request(REQ_CLEAR, 16'h0000, 32'h0000_0000);
		send_request(REQ_LOAD, 16'h0000, 32'hFFFF_FFFF);
		send_request(REQ_LOAD, 16'hFFFF, 32'h0000_0000);
		send_request(REQ_LOAD, 16'h0001, 32'h5555_5555);
		send_request(REQ_LOAD, 16'h8000, 32'hAAAA_AAAA);
		send_request(REQ_PICK, 16'hFFFF, 32'h0000_0000);
		send_request(REQ_PICK, 16'h0000, 32'hFFFF_FFFF);
		send_request(REQ_LOAD, 16'h5555, 32'h0000_0000);
		send_request(REQ_LOAD, 16'hAAAA, 32'h0000_0000);
		send_request(REQ_NOP, 16'h1234, 32'h8765_4321);
		send_request(REQ_PICK, 16'h0000, 32'h5555_5555);
		send_request(REQ_PICK, 16'h0000, 32'hAAAA_AAAA);
		send_request(REQ_PICK, 16'h0000, 32'h0000_0003);
		send_request(REQ_PICK, 16'h0000, 32'h8000_0000);
		send_request(REQ_PICK, 16'h0000, 32'h0000_0001);
		wait_drained();
	endtask

	// zero total fitness falls back to the last live entry
	task automatic test_zero_total();
		send_request(REQ_CLEAR, 16'h0000, 32'h0000_0000);
		send_request(REQ_LOAD, 16'h0000, 32'h0000_0000);
		send_request(REQ_LOAD, 16'h0007, 32'h0000_0000);
		send_request(REQ_LOAD, 16'h0000, 32'h0000_0000);
		send_request(REQ_PICK, 16'h0000, 32'h0000_0002);
		send_request(REQ_PICK, 16'h0000, 32'hFFFF_FFFF);
		send_request(REQ_PICK, 16'h0000, 32'h0000_0000);
		send_request(REQ_PICK, 16'h0000, 32'h0000_0000);
		wait_drained();
	endtask

	// full table rejects loads until the next clear, even after picks
	task automatic test_table_full();
		send_request(REQ_CLEAR, 16'h0000, 32'h0000_0000);
		repeat (TABLE_DEPTH)
			send_request(REQ_LOAD, rand_fitness(), rand_word());
		send_request(REQ_LOAD, 16'hFFFF, 32'h0000_0000);
		send_request(REQ_PICK, 16'h0000, rand_word());
		send_request(REQ_PICK, 16'h0000, 32'hFFFF_FFFF);
		send_request(REQ_LOAD, 16'h0001, 32'h0000_0000);
		send_request(REQ_CLEAR, 16'h0000, 32'h0000_0000);
		send_request(REQ_LOAD, 16'h4321, 32'h0000_0000);
		wait_drained();
	endtask

	// fill-and-drain sequences with random content, plus random noise
	task automatic test_random_selection(int unsigned budget);
		int unsigned stop_at, n_loads, n_picks;
		stop_at = sent_count + budget;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 4) != 0)
					send_request(REQ_CLEAR, rand_fitness(), $urandom);
				n_loads = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 66)
				                                      : $urandom_range(1, 10);
				repeat (n_loads)
					send_request(REQ_LOAD, rand_fitness(), $urandom);
				n_picks = n_loads + $urandom_range(0, 1);
				repeat (n_picks) begin
					if ($urandom_range(0, 7) == 0)
						send_request(REQ_LOAD, rand_fitness(), $urandom);
					send_request(REQ_PICK, rand_fitness(), rand_word());
				end
			end else begin
				repeat ($urandom_range(1, 6))
					send_request(req_t'($urandom_range(0, 3)), rand_fitness(), rand_word());
			end
		end
		wait_drained();
	endtask

	// test sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 18;
		recv_stall_pct = 61;
		test_empty_and_unused();
		test_field_extremes();
		test_zero_total();
		test_table_full();
		test_random_selection(200);

		send_idle_pct  = 61;
		recv_stall_pct = 18;
		test_random_selection(200);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_selection(200);

		repeat (END_SETTLE) @(posedge clk);
		if (error_count == 0 && expected_selections.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
